@@ rtl/lcd_rotating_digit_registers_defines.svh @@
// Assertion macros shared by the LCD rotating digit register RTL.
`ifndef LCD_ROTATING_DIGIT_REGISTERS_DEFINES_SVH
`define LCD_ROTATING_DIGIT_REGISTERS_DEFINES_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define LRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that, once seen, must be followed by another in the next clock cycle.
`define LRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRD_ASSERT(lbl, prop, msg)
`define LRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/lrd_pkg.sv @@
// Types, constants, transfer tables and microcode ROM of the LCD digit registers.
package lrd_pkg;

    // Cells in each circular register.
    localparam int DIGITS = 12;
    localparam int TOP    = DIGITS - 1;
    // Digits carried by one read or write beat.
    localparam int RD_DIGITS = 12;
    localparam int NIB_W     = 4;
    localparam int CNT_W     = 4;
    localparam int ANN_W     = 12;

    // Register select bits.
    localparam int LANE_A = 0;
    localparam int LANE_B = 1;
    localparam int LANE_C = 2;
    localparam logic [2:0] SEL_NONE = 3'b000;
    localparam logic [2:0] SEL_A    = 3'b001;
    localparam logic [2:0] SEL_B    = 3'b010;
    localparam logic [2:0] SEL_C    = 3'b100;
    localparam logic [2:0] SEL_AB   = SEL_A | SEL_B;
    localparam logic [2:0] SEL_ABC  = SEL_A | SEL_B | SEL_C;

    localparam logic END_LEFT  = 1'b1;
    localparam logic END_RIGHT = 1'b0;

    // Read variant that returns the annunciator word.
    localparam logic [3:0] N_ANN_READ = 4'h5;

    typedef enum logic [2:0] {
        CMD_READ     = 3'd0,
        CMD_WRITE    = 3'd1,
        CMD_ANN_WR   = 3'd2,
        CMD_DISP_OFF = 3'd3,
        CMD_DISP_TOG = 3'd4,
        CMD_SLEEP    = 3'd5
    } cmd_code_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  n;
        logic [47:0] write_data;
    } cmd_beat_t;

    typedef struct packed {
        logic [47:0] read_data;
        logic [3:0]  read_count;
        logic        display_on;
        logic        carry_set;
    } rsp_beat_t;

    typedef struct packed {
        logic [2:0]       sel;
        logic [CNT_W-1:0] chars;
        logic             left;
    } xfer_t;

    // Microcode addresses.
    typedef enum logic [3:0] {
        U_IDLE,
        U_MOVE_A,
        U_MOVE_B,
        U_MOVE_C,
        U_ANN_RD,
        U_ANN_WR,
        U_DISP_OFF,
        U_DISP_TOG,
        U_SLEEP,
        U_NOP,
        U_RESULT
    } upc_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_MOVE_A,
        ACT_MOVE_B,
        ACT_MOVE_C,
        ACT_ANN_RD,
        ACT_ANN_WR,
        ACT_DISP_OFF,
        ACT_DISP_TOG,
        ACT_SLEEP,
        ACT_RESULT
    } uact_t;

    typedef enum logic [1:0] {
        JMP_ALWAYS,
        JMP_DISPATCH,
        JMP_LANE,
        JMP_OUT_WAIT
    } ujmp_t;

    typedef struct packed {
        uact_t act;
        ujmp_t jmp;
        upc_t  target;
    } uword_t;

    function automatic xfer_t rd_xfer(logic [3:0] n);
        xfer_t x;
        unique case (n)
            4'h0:    x = '{SEL_A,    4'd12, END_LEFT};
            4'h1:    x = '{SEL_B,    4'd12, END_LEFT};
            4'h2:    x = '{SEL_C,    4'd12, END_LEFT};
            4'h3:    x = '{SEL_AB,   4'd6,  END_LEFT};
            4'h4:    x = '{SEL_ABC,  4'd4,  END_LEFT};
            4'h5:    x = '{SEL_NONE, 4'd0,  END_RIGHT};
            4'h6:    x = '{SEL_C,    4'd1,  END_LEFT};
            4'h7:    x = '{SEL_A,    4'd1,  END_RIGHT};
            4'h8:    x = '{SEL_B,    4'd1,  END_RIGHT};
            4'h9:    x = '{SEL_C,    4'd1,  END_RIGHT};
            4'ha:    x = '{SEL_A,    4'd1,  END_LEFT};
            4'hb:    x = '{SEL_B,    4'd1,  END_LEFT};
            4'hc:    x = '{SEL_AB,   4'd1,  END_RIGHT};
            4'hd:    x = '{SEL_AB,   4'd1,  END_LEFT};
            4'he:    x = '{SEL_ABC,  4'd1,  END_RIGHT};
            default: x = '{SEL_ABC,  4'd1,  END_LEFT};
        endcase
        return x;
    endfunction

    function automatic xfer_t wr_xfer(logic [3:0] n);
        xfer_t x;
        unique case (n)
            4'h0:    x = '{SEL_A,   4'd12, END_LEFT};
            4'h1:    x = '{SEL_B,   4'd12, END_LEFT};
            4'h2:    x = '{SEL_C,   4'd12, END_LEFT};
            4'h3:    x = '{SEL_AB,  4'd6,  END_LEFT};
            4'h4:    x = '{SEL_ABC, 4'd4,  END_LEFT};
            4'h5:    x = '{SEL_AB,  4'd6,  END_RIGHT};
            4'h6:    x = '{SEL_ABC, 4'd4,  END_RIGHT};
            4'h7:    x = '{SEL_A,   4'd1,  END_LEFT};
            4'h8:    x = '{SEL_B,   4'd1,  END_LEFT};
            4'h9:    x = '{SEL_C,   4'd1,  END_LEFT};
            4'ha:    x = '{SEL_A,   4'd1,  END_RIGHT};
            4'hb:    x = '{SEL_B,   4'd1,  END_RIGHT};
            4'hc:    x = '{SEL_C,   4'd1,  END_RIGHT};
            4'hd:    x = '{SEL_AB,  4'd1,  END_RIGHT};
            4'he:    x = '{SEL_ABC, 4'd1,  END_LEFT};
            default: x = '{SEL_ABC, 4'd1,  END_RIGHT};
        endcase
        return x;
    endfunction

    // Lowest selected register gives the first step of a character.
    function automatic upc_t first_lane(logic [2:0] sel);
        upc_t pc;
        if (sel[LANE_A]) begin
            pc = U_MOVE_A;
        end else if (sel[LANE_B]) begin
            pc = U_MOVE_B;
        end else if (sel[LANE_C]) begin
            pc = U_MOVE_C;
        end else begin
            pc = U_NOP;
        end
        return pc;
    endfunction

    // Entry point of the program for a new command.
    function automatic upc_t dispatch(cmd_beat_t c);
        upc_t pc;
        case (c.command)
            CMD_READ: begin
                if (c.n == N_ANN_READ) begin
                    pc = U_ANN_RD;
                end else begin
                    pc = first_lane(rd_xfer(c.n).sel);
                end
            end
            CMD_WRITE:    pc = first_lane(wr_xfer(c.n).sel);
            CMD_ANN_WR:   pc = U_ANN_WR;
            CMD_DISP_OFF: pc = U_DISP_OFF;
            CMD_DISP_TOG: pc = U_DISP_TOG;
            CMD_SLEEP:    pc = U_SLEEP;
            default:      pc = U_NOP;
        endcase
        return pc;
    endfunction

    // Control store: one word per step.
    function automatic uword_t ucode(upc_t pc);
        uword_t w;
        unique case (pc)
            U_IDLE:     w = '{ACT_NONE,     JMP_DISPATCH, U_IDLE};
            U_MOVE_A:   w = '{ACT_MOVE_A,   JMP_LANE,     U_RESULT};
            U_MOVE_B:   w = '{ACT_MOVE_B,   JMP_LANE,     U_RESULT};
            U_MOVE_C:   w = '{ACT_MOVE_C,   JMP_LANE,     U_RESULT};
            U_ANN_RD:   w = '{ACT_ANN_RD,   JMP_ALWAYS,   U_RESULT};
            U_ANN_WR:   w = '{ACT_ANN_WR,   JMP_ALWAYS,   U_RESULT};
            U_DISP_OFF: w = '{ACT_DISP_OFF, JMP_ALWAYS,   U_RESULT};
            U_DISP_TOG: w = '{ACT_DISP_TOG, JMP_ALWAYS,   U_RESULT};
            U_SLEEP:    w = '{ACT_SLEEP,    JMP_ALWAYS,   U_RESULT};
            U_NOP:      w = '{ACT_NONE,     JMP_ALWAYS,   U_RESULT};
            U_RESULT:   w = '{ACT_RESULT,   JMP_OUT_WAIT, U_IDLE};
            default:    w = '{ACT_NONE,     JMP_ALWAYS,   U_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/lcd_rotating_digit_registers.sv @@
// LCD driver digit registers: microcoded sequencer, rotating registers and result register.
//
// This block holds the three circular digit registers of an LCD driver (A and B with
// 4-bit digits, C with 1-bit digits), the 12-bit annunciator word and the display enable
// bit, and executes one command beat at a time. A small control store steps through the
// command: read and write commands move one digit per clock, each move rotating its
// register by one cell. Each command passes through a dispatch step, its move steps (or
// one step for an annunciator access, display off, toggle or sleep) and a result step.
// cmd_stall is high from the accepting edge until the sequencer has handed the result to
// the output register; the result beat then waits there, and a stalled result holds the
// sequencer on its final step. Read data fills from digit 0 upward and read_count gives
// the number of digits filled; other commands answer with zero read data. The digit
// registers, annunciator word and display bit reset to zero.
`include "lcd_rotating_digit_registers_defines.svh"

module lcd_rotating_digit_registers
    import lrd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_beat_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    // Sequencer state.
    upc_t      upc_reg;
    upc_t      upc_next;
    uword_t    uw;
    logic      chars_dec;
    logic      accept;
    logic      rsp_full;
    logic      slot_free;
    logic      do_result;
    logic      move_step;

    // Command context latched at dispatch.
    logic [2:0]       sel_reg;
    logic [CNT_W-1:0] chars_reg;
    logic             left_reg;
    logic             is_read_reg;
    logic [47:0]      wd_reg;
    logic [CNT_W-1:0] dig_cnt_reg;
    logic             carry_reg;
    xfer_t            xfer;

    // Architectural state.
    logic [NIB_W-1:0] digs_a_reg [DIGITS];
    logic [NIB_W-1:0] digs_b_reg [DIGITS];
    logic             digs_c_reg [DIGITS];
    logic [ANN_W-1:0] ann_reg;
    logic             disp_reg;

    // Read data under collection.
    logic [NIB_W-1:0] rd_reg [RD_DIGITS];
    logic [47:0]      rd_flat;

    // Result register.
    logic      rsp_valid_reg;
    rsp_beat_t rsp_reg;

    // Datapath signals of one digit move.
    logic             toward_left;
    logic             cnt_in_range;
    logic [NIB_W-1:0] wd_nib;
    logic [NIB_W-1:0] end_a;
    logic [NIB_W-1:0] end_b;
    logic             end_c;
    logic [NIB_W-1:0] fill_a;
    logic [NIB_W-1:0] fill_b;
    logic             fill_c;
    logic [NIB_W-1:0] move_digit;

    assign uw        = ucode(upc_reg);
    assign accept    = cmd_valid && (upc_reg == U_IDLE);
    assign cmd_stall = (upc_reg != U_IDLE);
    assign rsp_full  = rsp_valid_reg && rsp_stall;
    assign slot_free = !rsp_full;
    assign do_result = (uw.act == ACT_RESULT) && slot_free;
    assign move_step = (uw.act == ACT_MOVE_A) || (uw.act == ACT_MOVE_B) ||
                       (uw.act == ACT_MOVE_C);
    assign xfer      = (cmd.command == CMD_READ) ? rd_xfer(cmd.n) : wr_xfer(cmd.n);

    // Next step: sequential jumps, dispatch, lane walk and output wait.
    always_comb begin
        upc_next  = upc_reg;
        chars_dec = 1'b0;
        unique case (uw.jmp)
            JMP_ALWAYS: upc_next = uw.target;
            JMP_DISPATCH: begin
                if (accept) begin
                    upc_next = dispatch(cmd);
                end
            end
            JMP_LANE: begin
                if ((uw.act == ACT_MOVE_A) && sel_reg[LANE_B]) begin
                    upc_next = U_MOVE_B;
                end else if ((uw.act != ACT_MOVE_C) && sel_reg[LANE_C]) begin
                    upc_next = U_MOVE_C;
                end else if (chars_reg > CNT_W'(1)) begin
                    upc_next  = first_lane(sel_reg);
                    chars_dec = 1'b1;
                end else begin
                    upc_next = uw.target;
                end
            end
            JMP_OUT_WAIT: begin
                if (slot_free) begin
                    upc_next = uw.target;
                end
            end
            default: upc_next = U_IDLE;
        endcase
    end

    // A read takes the end cell and turns the register toward that end; a write turns
    // it the other way and drops the new digit into the end cell.
    assign toward_left  = !(is_read_reg ^ left_reg);
    assign cnt_in_range = (dig_cnt_reg < CNT_W'(RD_DIGITS));
    assign wd_nib       = cnt_in_range ? wd_reg[{dig_cnt_reg, 2'b00} +: NIB_W] : '0;
    assign end_a        = left_reg ? digs_a_reg[TOP] : digs_a_reg[0];
    assign end_b        = left_reg ? digs_b_reg[TOP] : digs_b_reg[0];
    assign end_c        = left_reg ? digs_c_reg[TOP] : digs_c_reg[0];
    assign fill_a       = is_read_reg ? end_a : wd_nib;
    assign fill_b       = is_read_reg ? end_b : wd_nib;
    assign fill_c       = is_read_reg ? end_c : wd_nib[0];

    always_comb begin
        case (uw.act)
            ACT_MOVE_A: move_digit = end_a;
            ACT_MOVE_B: move_digit = end_b;
            ACT_MOVE_C: move_digit = {{(NIB_W-1){1'b0}}, end_c};
            default:    move_digit = '0;
        endcase
    end

    // Sequencer and result register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            upc_reg       <= U_IDLE;
            rsp_valid_reg <= 1'b0;
        end else begin
            upc_reg <= upc_next;
            if (do_result) begin
                rsp_valid_reg <= 1'b1;
            end else if (!rsp_stall) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_result) begin
            rsp_reg.read_data  <= rd_flat;
            rsp_reg.read_count <= is_read_reg ? dig_cnt_reg : '0;
            rsp_reg.display_on <= disp_reg;
            rsp_reg.carry_set  <= carry_reg;
        end
    end

    // Command context, digit registers and the small state words.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sel_reg     <= SEL_NONE;
            chars_reg   <= '0;
            left_reg    <= END_RIGHT;
            is_read_reg <= 1'b0;
            dig_cnt_reg <= '0;
            carry_reg   <= 1'b0;
            ann_reg     <= '0;
            disp_reg    <= 1'b0;
            for (int i = 0; i < DIGITS; i++) begin
                digs_a_reg[i] <= '0;
                digs_b_reg[i] <= '0;
                digs_c_reg[i] <= 1'b0;
            end
        end else begin
            if (accept) begin
                sel_reg     <= xfer.sel;
                chars_reg   <= xfer.chars;
                left_reg    <= xfer.left;
                is_read_reg <= (cmd.command == CMD_READ);
                dig_cnt_reg <= '0;
                carry_reg   <= 1'b0;
            end
            if (chars_dec) begin
                chars_reg <= chars_reg - CNT_W'(1);
            end
            case (uw.act) inside
                ACT_MOVE_A, ACT_MOVE_B, ACT_MOVE_C: dig_cnt_reg <= dig_cnt_reg + CNT_W'(1);
                ACT_ANN_RD:   dig_cnt_reg <= CNT_W'(ANN_W / NIB_W);
                ACT_ANN_WR:   ann_reg     <= wd_reg[ANN_W-1:0];
                ACT_DISP_OFF: disp_reg    <= 1'b0;
                ACT_DISP_TOG: disp_reg    <= !disp_reg;
                ACT_SLEEP:    carry_reg   <= !disp_reg;
                default:      ;
            endcase
            if (uw.act == ACT_MOVE_A) begin
                if (toward_left) begin
                    for (int i = 1; i < DIGITS; i++) begin
                        digs_a_reg[i] <= digs_a_reg[i-1];
                    end
                    digs_a_reg[0] <= fill_a;
                end else begin
                    for (int i = 0; i < TOP; i++) begin
                        digs_a_reg[i] <= digs_a_reg[i+1];
                    end
                    digs_a_reg[TOP] <= fill_a;
                end
            end
            if (uw.act == ACT_MOVE_B) begin
                if (toward_left) begin
                    for (int i = 1; i < DIGITS; i++) begin
                        digs_b_reg[i] <= digs_b_reg[i-1];
                    end
                    digs_b_reg[0] <= fill_b;
                end else begin
                    for (int i = 0; i < TOP; i++) begin
                        digs_b_reg[i] <= digs_b_reg[i+1];
                    end
                    digs_b_reg[TOP] <= fill_b;
                end
            end
            if (uw.act == ACT_MOVE_C) begin
                if (toward_left) begin
                    for (int i = 1; i < DIGITS; i++) begin
                        digs_c_reg[i] <= digs_c_reg[i-1];
                    end
                    digs_c_reg[0] <= fill_c;
                end else begin
                    for (int i = 0; i < TOP; i++) begin
                        digs_c_reg[i] <= digs_c_reg[i+1];
                    end
                    digs_c_reg[TOP] <= fill_c;
                end
            end
        end
    end

    // Payload registers: the held write digits and the read digits collected so far.
    always_ff @(posedge clk) begin
        if (accept) begin
            wd_reg <= cmd.write_data;
            for (int i = 0; i < RD_DIGITS; i++) begin
                rd_reg[i] <= '0;
            end
        end else if (uw.act == ACT_ANN_RD) begin
            for (int i = 0; i < ANN_W / NIB_W; i++) begin
                rd_reg[i] <= ann_reg[i*NIB_W +: NIB_W];
            end
        end else if (is_read_reg && cnt_in_range && move_step) begin
            rd_reg[dig_cnt_reg] <= move_digit;
        end
    end

    always_comb begin
        for (int i = 0; i < RD_DIGITS; i++) begin
            rd_flat[i*NIB_W +: NIB_W] = rd_reg[i];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An accepted command always leaves the idle step.
    `LRD_ASSERT_NEXT(a_leave_idle, accept, upc_reg != U_IDLE, "sequencer stayed idle")
    // The digit counter never passes the digits of one beat.
    `LRD_ASSERT(a_cnt_range, dig_cnt_reg <= CNT_W'(RD_DIGITS), "digit count out of range")
    // A digit move only runs with characters left to transfer.
    `LRD_ASSERT(a_chars_live, move_step |-> (chars_reg != '0), "move with no characters left")
    // A stalled result beat stays valid and keeps its payload.
    `LRD_ASSERT_NEXT(a_rsp_hold, rsp_full, rsp_valid && $stable(rsp), "stalled beat changed")

endmodule
